>>> hdl/ordered_list_engine_assert.svh
// ------------------------------------------------------------------------
// ordered_list_engine_assert.svh
// Assertion macros for the ordered list engine sequencer. They use the
// clk and rst_n signals of the module that expands them.
// ------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define OLE_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("ordered_list_engine: assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define OLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_list_engine: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_list_engine: assertion failed");

`else

`define OLE_ASSERT(lbl, cond)
`define OLE_ASSERT_IMPL(lbl, ante, cons)
`define OLE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> hdl/ole_pkg.sv
// ------------------------------------------------------------------------
// ole_pkg
// Types and constants shared by the ordered list engine.
// ------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int OPCODE_W     = 4;
  localparam int POSITION_W   = 8;
  localparam int STATUS_W     = 2;
  localparam int COUNT_W      = 9;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_FRONT = 4'd0,
    OP_PUSH_BACK  = 4'd1,
    OP_SET_PUSH   = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_DELETE_AT  = 4'd5,
    OP_REMOVE_ONE = 4'd6,
    OP_REMOVE_ALL = 4'd7,
    OP_READ_AT    = 4'd8,
    OP_EXISTS     = 4'd9,
    OP_IS_FIRST   = 4'd10,
    OP_CLEAR      = 4'd11
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_RD,
    S_SHUP,
    S_PUT0,
    S_SHDN,
    S_COMPACT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0]   result_value;
    logic [STATUS_W-1:0] status;
    logic                hit;
    logic [COUNT_W-1:0]  count;
  } res_t;

endpackage

>>> hdl/ole_ram.sv
// ------------------------------------------------------------------------
// ole_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// ------------------------------------------------------------------------
module ole_ram #(
  parameter int WIDTH = ole_pkg::DATA_W,
  parameter int DEPTH = ole_pkg::CAPACITY_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/ole_seq.sv
// ------------------------------------------------------------------------
// ole_seq
// Operation sequencer: decodes one item, walks the entry memory one entry
// per cycle for shifts, searches and compaction, and keeps the fill count.
// ------------------------------------------------------------------------
`include "ordered_list_engine_assert.svh"

module ole_seq #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF,
  localparam int AW      = $clog2(CAPACITY),
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ole_pkg::OPCODE_W-1:0]  in_opcode,
  input  logic [ole_pkg::DATA_W-1:0]    in_value,
  input  logic [ole_pkg::POSITION_W-1:0] in_position,
  output logic                          res_valid,
  input  logic                          res_ready,
  output ole_pkg::res_t                 res,
  output logic                          ram_we,
  output logic [AW-1:0]                 ram_waddr,
  output logic [ole_pkg::DATA_W-1:0]    ram_wdata,
  output logic                          ram_re,
  output logic [AW-1:0]                 ram_raddr,
  input  logic [ole_pkg::DATA_W-1:0]    ram_rdata
);

  localparam int PXW = (CW > ole_pkg::POSITION_W) ? CW : ole_pkg::POSITION_W;
  localparam int CXW = (CW > ole_pkg::COUNT_W) ? CW : ole_pkg::COUNT_W;

  ole_pkg::state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  ole_pkg::opcode_t op_r, op_nxt;
  logic [ole_pkg::DATA_W-1:0] val_r, val_nxt;
  logic [AW-1:0]    ra_r, ra_nxt;
  logic [CW-1:0]    w_r, w_nxt;
  logic [ole_pkg::DATA_W-1:0] rv_r, rv_nxt;
  ole_pkg::status_t st_r, st_nxt;
  logic             hit_r, hit_nxt;

  logic             acc;
  logic             full;
  logic             empty;
  logic             oor;
  logic [PXW-1:0]   pos_x;
  logic [PXW-1:0]   cnt_p;
  logic [CXW-1:0]   cnt_x;
  logic [CW-1:0]    ra_inc;
  logic             ra_more;
  logic             match;
  logic             keep;
  logic [CW-1:0]    w_fin;
  logic             rm_go;
  logic [AW-1:0]    rm_idx;
  logic [CW-1:0]    rm_inc;
  logic [CW-1:0]    waddr_x;

  assign acc     = in_valid && in_ready;
  assign full    = (cnt_r == CW'(CAPACITY));
  assign empty   = (cnt_r == '0);
  assign pos_x   = PXW'(in_position);
  assign cnt_p   = PXW'(cnt_r);
  assign oor     = (pos_x >= cnt_p);
  assign cnt_x   = CXW'(cnt_r);
  assign ra_inc  = CW'(ra_r) + CW'(1);
  assign ra_more = (ra_inc < cnt_r);
  assign match   = (ram_rdata == val_r);
  assign keep    = !match;
  assign w_fin   = w_r + CW'(keep);
  assign rm_inc  = CW'(rm_idx) + CW'(1);
  assign waddr_x = CW'(ram_waddr);

  assign in_ready  = (state_r == ole_pkg::S_IDLE);
  assign res_valid = (state_r == ole_pkg::S_FIN);

  always_comb begin
    res.result_value = rv_r;
    res.status       = st_r;
    res.hit          = hit_r;
    res.count        = cnt_x[ole_pkg::COUNT_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    ra_nxt    = ra_r;
    w_nxt     = w_r;
    rv_nxt    = rv_r;
    st_nxt    = st_r;
    hit_nxt   = hit_r;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    rm_go     = 1'b0;
    rm_idx    = '0;

    case (state_r)
      ole_pkg::S_IDLE: begin
        if (acc) begin
          op_nxt    = ole_pkg::opcode_t'(in_opcode);
          val_nxt   = in_value;
          rv_nxt    = '0;
          st_nxt    = ole_pkg::ST_OK;
          hit_nxt   = 1'b0;
          state_nxt = ole_pkg::S_FIN;
          case (ole_pkg::opcode_t'(in_opcode))
            ole_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                st_nxt = ole_pkg::ST_FULL;
              end else if (empty) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_value;
                cnt_nxt   = cnt_r + CW'(1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cnt_r - CW'(1));
                ra_nxt    = AW'(cnt_r - CW'(1));
                state_nxt = ole_pkg::S_SHUP;
              end
            end
            ole_pkg::OP_PUSH_BACK: begin
              if (full) begin
                st_nxt = ole_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = in_value;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            ole_pkg::OP_SET_PUSH: begin
              if (empty) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = in_value;
                cnt_nxt   = cnt_r + CW'(1);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ra_nxt    = '0;
                state_nxt = ole_pkg::S_FIND;
              end
            end
            ole_pkg::OP_POP_FRONT: begin
              if (empty) begin
                st_nxt = ole_pkg::ST_MISS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = ole_pkg::S_RD;
              end
            end
            ole_pkg::OP_POP_BACK: begin
              if (empty) begin
                st_nxt = ole_pkg::ST_MISS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(cnt_r - CW'(1));
                state_nxt = ole_pkg::S_RD;
              end
            end
            ole_pkg::OP_DELETE_AT: begin
              if (oor) begin
                st_nxt = ole_pkg::ST_MISS;
              end else begin
                rm_go  = 1'b1;
                rm_idx = AW'(in_position);
              end
            end
            ole_pkg::OP_REMOVE_ONE: begin
              if (empty) begin
                st_nxt = ole_pkg::ST_MISS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ra_nxt    = '0;
                state_nxt = ole_pkg::S_FIND;
              end
            end
            ole_pkg::OP_REMOVE_ALL: begin
              if (empty) begin
                st_nxt = ole_pkg::ST_MISS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ra_nxt    = '0;
                w_nxt     = '0;
                state_nxt = ole_pkg::S_COMPACT;
              end
            end
            ole_pkg::OP_READ_AT: begin
              if (oor) begin
                st_nxt = ole_pkg::ST_MISS;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_position);
                state_nxt = ole_pkg::S_RD;
              end
            end
            ole_pkg::OP_EXISTS: begin
              if (!empty) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                ra_nxt    = '0;
                state_nxt = ole_pkg::S_FIND;
              end
            end
            ole_pkg::OP_IS_FIRST: begin
              if (!empty) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_nxt = ole_pkg::S_RD;
              end
            end
            ole_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ole_pkg::S_FIND: begin
        if (match) begin
          state_nxt = ole_pkg::S_FIN;
          case (op_r)
            ole_pkg::OP_REMOVE_ONE: begin
              rm_go  = 1'b1;
              rm_idx = ra_r;
            end
            ole_pkg::OP_EXISTS: begin
              hit_nxt = 1'b1;
            end
            default: begin
            end
          endcase
        end else if (ra_more) begin
          ram_re    = 1'b1;
          ram_raddr = ra_inc[AW-1:0];
          ra_nxt    = ra_inc[AW-1:0];
        end else begin
          state_nxt = ole_pkg::S_FIN;
          case (op_r)
            ole_pkg::OP_REMOVE_ONE: begin
              st_nxt = ole_pkg::ST_MISS;
            end
            ole_pkg::OP_SET_PUSH: begin
              if (full) begin
                st_nxt = ole_pkg::ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = cnt_r[AW-1:0];
                ram_wdata = val_r;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end

      ole_pkg::S_RD: begin
        state_nxt = ole_pkg::S_FIN;
        case (op_r)
          ole_pkg::OP_POP_FRONT: begin
            rv_nxt = ram_rdata;
            rm_go  = 1'b1;
            rm_idx = '0;
          end
          ole_pkg::OP_POP_BACK: begin
            rv_nxt  = ram_rdata;
            cnt_nxt = cnt_r - CW'(1);
          end
          ole_pkg::OP_IS_FIRST: begin
            hit_nxt = match;
          end
          default: begin
            rv_nxt = ram_rdata;
          end
        endcase
      end

      ole_pkg::S_SHUP: begin
        ram_we    = 1'b1;
        ram_waddr = ra_inc[AW-1:0];
        ram_wdata = ram_rdata;
        if (ra_r != '0) begin
          ram_re    = 1'b1;
          ram_raddr = ra_r - AW'(1);
          ra_nxt    = ra_r - AW'(1);
        end else begin
          state_nxt = ole_pkg::S_PUT0;
        end
      end

      ole_pkg::S_PUT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = ole_pkg::S_FIN;
      end

      ole_pkg::S_SHDN: begin
        ram_we    = 1'b1;
        ram_waddr = ra_r - AW'(1);
        ram_wdata = ram_rdata;
        if (ra_more) begin
          ram_re    = 1'b1;
          ram_raddr = ra_inc[AW-1:0];
          ra_nxt    = ra_inc[AW-1:0];
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = ole_pkg::S_FIN;
        end
      end

      ole_pkg::S_COMPACT: begin
        if (keep) begin
          ram_we    = 1'b1;
          ram_waddr = w_r[AW-1:0];
          ram_wdata = ram_rdata;
        end
        w_nxt = w_fin;
        if (ra_more) begin
          ram_re    = 1'b1;
          ram_raddr = ra_inc[AW-1:0];
          ra_nxt    = ra_inc[AW-1:0];
        end else begin
          if (w_fin == cnt_r) begin
            st_nxt = ole_pkg::ST_MISS;
          end
          cnt_nxt   = w_fin;
          state_nxt = ole_pkg::S_FIN;
        end
      end

      ole_pkg::S_FIN: begin
        if (res_ready) begin
          state_nxt = ole_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ole_pkg::S_IDLE;
      end
    endcase

    // A removal at one index either shifts the tail down or only shortens
    // the list when the index is the last entry.
    if (rm_go) begin
      if (rm_inc < cnt_r) begin
        ram_re    = 1'b1;
        ram_raddr = rm_inc[AW-1:0];
        ra_nxt    = rm_inc[AW-1:0];
        state_nxt = ole_pkg::S_SHDN;
      end else begin
        cnt_nxt   = cnt_r - CW'(1);
        state_nxt = ole_pkg::S_FIN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ole_pkg::S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    val_r <= val_nxt;
    ra_r  <= ra_nxt;
    w_r   <= w_nxt;
    rv_r  <= rv_nxt;
    st_r  <= st_nxt;
    hit_r <= hit_nxt;
  end

  `OLE_ASSERT(a_cnt_max, cnt_r <= CW'(CAPACITY))
  `OLE_ASSERT_IMPL(a_res_excl, res_valid, !in_ready)
  `OLE_ASSERT_IMPL(a_wr_bound, ram_we, waddr_x <= cnt_r)
  `OLE_ASSERT_NEXT(a_cnt_idle, in_ready && !in_valid, $stable(cnt_r))

endmodule

>>> hdl/ordered_list_engine.sv
// ------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values held in one RAM, with push, pop,
// delete, remove, read, membership and clear operations.
// ------------------------------------------------------------------------
// Push back, clear and out-of-range or empty cases go from decode straight to
// the result state; reads and pops at the back first pass the RAM read state.
// Shifts, searches and remove-all walk the list one entry per cycle through
// the single RAM read port. One item is in work at a time; a new beat is
// taken while a result waits in the output register. Reset clears the fill
// count and control state.
module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ole_pkg::OPCODE_W-1:0]   in_opcode,
  input  logic signed [ole_pkg::DATA_W-1:0] in_value,
  input  logic [ole_pkg::POSITION_W-1:0] in_position,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ole_pkg::DATA_W-1:0] out_result_value,
  output logic [ole_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_hit,
  output logic [ole_pkg::COUNT_W-1:0]    out_count
);

  localparam int AW = $clog2(CAPACITY);

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [ole_pkg::DATA_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [ole_pkg::DATA_W-1:0] ram_rdata;
  logic                       res_valid;
  logic                       res_ready;
  ole_pkg::res_t              res;
  logic                       out_valid_r, out_valid_nxt;
  ole_pkg::res_t              out_r;

  ole_ram #(
    .WIDTH (ole_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  ole_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_value    (in_value),
    .in_position (in_position),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  // The output register takes a new result when it is empty or its beat
  // completes in the same cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_r.result_value;
  assign out_status       = out_r.status;
  assign out_hit          = out_r.hit;
  assign out_count        = out_r.count;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for ordered_list_engine
// Drives opcodes into the list engine over its valid/ready input channel and
// compares every result beat against a cycle-free model of the list held in
// the bench. Directed corner cases come first, then a fill to capacity,
// random operation mixes under varying idle ratios, and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int OPCODE_W = ole_pkg::OPCODE_W;
  localparam int DATA_W = ole_pkg::DATA_W;
  localparam int POSITION_W = ole_pkg::POSITION_W;
  localparam int STATUS_W = ole_pkg::STATUS_W;
  localparam int COUNT_W = ole_pkg::COUNT_W;
  localparam int LIST_CAP = ole_pkg::CAPACITY_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 400;
  localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd12;
  localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;
  localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh80000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POSITION_W-1:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] out_result_value;
  logic [STATUS_W-1:0] out_status;
  logic out_hit;
  logic [COUNT_W-1:0] out_count;

  logic signed [DATA_W-1:0] list_entries [LIST_CAP];
  int list_count = 0;
  ole_pkg::res_t pending_results [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  ordered_list_engine dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .out_hit          (out_hit),
    .out_count        (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void drop_entry(int idx);
    int i;
    for (i = idx; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
    list_count--;
  endfunction

  function automatic ole_pkg::res_t apply_to_list(logic [OPCODE_W-1:0] op,
                                                  logic signed [DATA_W-1:0] v,
                                                  logic [POSITION_W-1:0] pos);
    ole_pkg::res_t r;
    int i;
    int w;
    int idx;
    bit found;
    r.result_value = '0;
    r.status = ole_pkg::ST_OK;
    r.hit = 1'b0;
    found = 1'b0;
    idx = 0;
    for (i = 0; i < list_count; i++) begin
      if (!found && list_entries[i] == v) begin
        found = 1'b1;
        idx = i;
      end
    end
    case (op)
      ole_pkg::OP_PUSH_FRONT: begin
        if (list_count >= LIST_CAP) begin
          r.status = ole_pkg::ST_FULL;
        end else begin
          for (i = list_count; i > 0; i--) list_entries[i] = list_entries[i - 1];
          list_entries[0] = v;
          list_count++;
        end
      end
      ole_pkg::OP_PUSH_BACK, ole_pkg::OP_SET_PUSH: begin
        if (op == ole_pkg::OP_SET_PUSH && found) begin
          r.status = ole_pkg::ST_OK;
        end else if (list_count >= LIST_CAP) begin
          r.status = ole_pkg::ST_FULL;
        end else begin
          list_entries[list_count] = v;
          list_count++;
        end
      end
      ole_pkg::OP_POP_FRONT: begin
        if (list_count == 0) begin
          r.status = ole_pkg::ST_MISS;
        end else begin
          r.result_value = list_entries[0];
          drop_entry(0);
        end
      end
      ole_pkg::OP_POP_BACK: begin
        if (list_count == 0) begin
          r.status = ole_pkg::ST_MISS;
        end else begin
          r.result_value = list_entries[list_count - 1];
          list_count--;
        end
      end
      ole_pkg::OP_DELETE_AT: begin
        if (pos >= list_count) r.status = ole_pkg::ST_MISS;
        else drop_entry(pos);
      end
      ole_pkg::OP_REMOVE_ONE: begin
        if (found) drop_entry(idx);
        else r.status = ole_pkg::ST_MISS;
      end
      ole_pkg::OP_REMOVE_ALL: begin
        w = 0;
        for (i = 0; i < list_count; i++) begin
          if (list_entries[i] != v) begin
            list_entries[w] = list_entries[i];
            w++;
          end
        end
        if (w == list_count) r.status = ole_pkg::ST_MISS;
        list_count = w;
      end
      ole_pkg::OP_READ_AT: begin
        if (pos >= list_count) r.status = ole_pkg::ST_MISS;
        else r.result_value = list_entries[pos];
      end
      ole_pkg::OP_EXISTS: r.hit = found;
      ole_pkg::OP_IS_FIRST: r.hit = (list_count > 0 && list_entries[0] == v);
      ole_pkg::OP_CLEAR: list_count = 0;
      default: r.status = ole_pkg::ST_OK;
    endcase
    r.count = list_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic signed [DATA_W-1:0] v,
                           input logic [POSITION_W-1:0] pos);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_value <= v;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_to_list(op, v, pos));
  endtask

  always @(negedge clk) begin
    if (hold_left == 0 && hold_requests != hold_served) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    ole_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: value %0d status %0d hit %0d count %0d",
                                       out_result_value, out_status, out_hit, out_count);
      end else begin
        want = pending_results.pop_front();
        if (out_result_value !== want.result_value || out_status !== want.status ||
            out_hit !== want.hit || out_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected value %0d status %0d hit %0d count %0d, got %0d %0d %0d %0d",
                     $signed(want.result_value), want.status, want.hit, want.count,
                     out_result_value, out_status, out_hit, out_count);
        end
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] pool [8];
    pool = '{0, -1, 1, VALUE_MAX, VALUE_MIN, 5, 42, -100};
    if ($urandom_range(99) < 75) return pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic logic [POSITION_W-1:0] pick_position();
    int p;
    if (list_count > 0 && $urandom_range(99) < 80) begin
      p = $urandom_range(list_count);
      return (p > 255) ? 8'd255 : p[POSITION_W-1:0];
    end
    return POSITION_W'($urandom_range(255));
  endfunction

  function automatic logic [OPCODE_W-1:0] pick_opcode(int push_weight);
    int roll;
    roll = $urandom_range(99);
    if (roll < push_weight)
      return OPCODE_W'($urandom_range(ole_pkg::OP_SET_PUSH, ole_pkg::OP_PUSH_FRONT));
    if (roll < push_weight + 1) return ole_pkg::OP_CLEAR;
    if (roll < push_weight + 3) return OPCODE_W'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
    return OPCODE_W'($urandom_range(ole_pkg::OP_IS_FIRST, ole_pkg::OP_POP_FRONT));
  endfunction

  task automatic test_directed();
    logic [OPCODE_W-1:0] op;
    send_item(ole_pkg::OP_POP_FRONT, 0, 0);
    send_item(ole_pkg::OP_POP_BACK, 0, 0);
    send_item(ole_pkg::OP_READ_AT, 0, 0);
    send_item(ole_pkg::OP_DELETE_AT, 0, 8'd255);
    send_item(ole_pkg::OP_IS_FIRST, 0, 0);
    send_item(ole_pkg::OP_REMOVE_ONE, 7, 0);
    send_item(ole_pkg::OP_REMOVE_ALL, 7, 0);
    send_item(ole_pkg::OP_PUSH_BACK, VALUE_MIN, 0);
    send_item(ole_pkg::OP_PUSH_FRONT, VALUE_MAX, 0);
    send_item(ole_pkg::OP_SET_PUSH, VALUE_MIN, 0);
    send_item(ole_pkg::OP_SET_PUSH, 0, 0);
    send_item(ole_pkg::OP_PUSH_BACK, VALUE_MIN, 0);
    send_item(ole_pkg::OP_PUSH_BACK, VALUE_MIN, 0);
    send_item(ole_pkg::OP_READ_AT, 0, 8'd4);
    send_item(ole_pkg::OP_READ_AT, 0, 8'd5);
    send_item(ole_pkg::OP_EXISTS, 0, 0);
    send_item(ole_pkg::OP_IS_FIRST, VALUE_MAX, 0);
    send_item(ole_pkg::OP_REMOVE_ALL, VALUE_MIN, 0);
    send_item(ole_pkg::OP_REMOVE_ONE, 0, 0);
    send_item(ole_pkg::OP_PUSH_BACK, -1, 0);
    send_item(ole_pkg::OP_DELETE_AT, 0, 0);
    send_item(ole_pkg::OP_PUSH_FRONT, 1, 0);
    send_item(ole_pkg::OP_POP_BACK, 0, 0);
    for (op = OP_SPARE_LO; op != OP_SPARE_LO - 1'b1; op++) begin
      send_item(op, $urandom, POSITION_W'($urandom_range(255)));
      if (op == OP_SPARE_HI) break;
    end
    send_item(ole_pkg::OP_CLEAR, 0, 0);
  endtask

  task automatic test_fill_to_full();
    int i;
    logic signed [DATA_W-1:0] v;
    while (list_count < LIST_CAP) begin
      v = ($urandom_range(99) < 70) ? $signed($urandom) : pick_value();
      send_item(OPCODE_W'($urandom_range(ole_pkg::OP_SET_PUSH, ole_pkg::OP_PUSH_FRONT)), v,
                POSITION_W'($urandom_range(255)));
    end
    for (i = 0; i < 6; i++)
      send_item(OPCODE_W'($urandom_range(ole_pkg::OP_SET_PUSH, ole_pkg::OP_PUSH_FRONT)),
                $urandom, 0);
    send_item(ole_pkg::OP_SET_PUSH, list_entries[0], 0);
    send_item(ole_pkg::OP_SET_PUSH, list_entries[LIST_CAP - 1], 0);
    send_item(ole_pkg::OP_READ_AT, 0, 8'd255);
    send_item(ole_pkg::OP_IS_FIRST, list_entries[0], 0);
    send_item(ole_pkg::OP_EXISTS, list_entries[LIST_CAP - 1], 0);
    send_item(ole_pkg::OP_DELETE_AT, 0, 8'd255);
    send_item(ole_pkg::OP_PUSH_FRONT, VALUE_MIN, 0);
    send_item(ole_pkg::OP_POP_FRONT, 0, 0);
    send_item(ole_pkg::OP_REMOVE_ALL, pick_value(), 0);
  endtask

  task automatic test_random_mix(int n_items, int push_weight);
    int i;
    for (i = 0; i < n_items; i++) send_item(pick_opcode(push_weight), pick_value(), pick_position());
  endtask

  task automatic test_output_stall();
    int i;
    int saved_idle;
    saved_idle = send_idle_pct;
    send_idle_pct = 0;
    hold_requests++;
    for (i = 0; i < 24; i++) send_item(pick_opcode(60), pick_value(), pick_position());
    send_idle_pct = saved_idle;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 52;
    test_directed();
    test_fill_to_full();
    test_random_mix(180, 50);

    send_idle_pct = 52;
    recv_idle_pct = 18;
    test_random_mix(450, 55);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(450, 45);
    test_output_stall();
    test_random_mix(40, 50);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
